// ===== rtl/core/emr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// emr_pkg
// Shared command codes and status type for the midpoint ellipse rasterizer
// controller and datapath.
// ----------------------------------------------------------------------------
package emr_pkg;

	typedef logic [3:0] emr_cmd_t;

	localparam emr_cmd_t CMD_NOP       = 4'd0;
	localparam emr_cmd_t CMD_LOAD      = 4'd1;
	localparam emr_cmd_t CMD_SQ        = 4'd2;
	localparam emr_cmd_t CMD_INIT_MUL  = 4'd3;
	localparam emr_cmd_t CMD_INIT_DEC  = 4'd4;
	localparam emr_cmd_t CMD_R1_CMP    = 4'd5;
	localparam emr_cmd_t CMD_R1_MUL    = 4'd6;
	localparam emr_cmd_t CMD_R1_UPD    = 4'd7;
	localparam emr_cmd_t CMD_R2_SQ     = 4'd8;
	localparam emr_cmd_t CMD_R2_MUL    = 4'd9;
	localparam emr_cmd_t CMD_R2_SET    = 4'd10;
	localparam emr_cmd_t CMD_R2_STEP   = 4'd11;
	localparam emr_cmd_t CMD_R2_UPD    = 4'd12;
	localparam emr_cmd_t CMD_EMIT      = 4'd13;
	localparam emr_cmd_t CMD_EMIT_LAST = 4'd14;

	typedef struct packed {
		logic lt;        // region 1 slope test still holds
		logic y_pos;     // current y offset is above zero
		logic out_free;  // output register can take a point this cycle
	} emr_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/emr_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// emr_ctrl
// Sequencer for the ellipse rasterizer: accepts input transactions, tracks
// the drawing region and issues one datapath command per cycle (a NOP while it waits).
// ----------------------------------------------------------------------------
module emr_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic                op,
	input  wire emr_pkg::emr_status_t status,
	output emr_pkg::emr_cmd_t        cmd
);
	import emr_pkg::*;

	localparam logic [3:0] ST_READY     = 4'd0;
	localparam logic [3:0] ST_SQ        = 4'd1;
	localparam logic [3:0] ST_INIT_MUL  = 4'd2;
	localparam logic [3:0] ST_INIT_DEC  = 4'd3;
	localparam logic [3:0] ST_R1_DECIDE = 4'd4;
	localparam logic [3:0] ST_R1_UPD    = 4'd5;
	localparam logic [3:0] ST_R2_MUL    = 4'd6;
	localparam logic [3:0] ST_R2_SET    = 4'd7;
	localparam logic [3:0] ST_R2_EMIT   = 4'd8;
	localparam logic [3:0] ST_R2_UPD    = 4'd9;
	localparam logic [3:0] ST_EMIT      = 4'd10;
	localparam logic [3:0] ST_EMIT_LAST = 4'd11;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_R1   = 2'd1;
	localparam logic [1:0] PH_R2   = 2'd2;

	logic [3:0] state_q, state_d;
	logic [1:0] phase_q, phase_d;

	always_comb begin
		state_d  = state_q;
		phase_d  = phase_q;
		cmd      = CMD_NOP;
		in_stall = (state_q != ST_READY);
		case (state_q)
			ST_READY: begin
				if (in_valid) begin
					if (!op) begin
						cmd     = CMD_LOAD;
						state_d = ST_SQ;
					end else begin
						case (phase_q)
							PH_R1: begin
								cmd     = CMD_R1_CMP;
								state_d = ST_R1_DECIDE;
							end
							PH_R2: begin
								if (status.y_pos) begin
									state_d = ST_R2_EMIT;
								end else begin
									state_d = ST_EMIT_LAST;
									phase_d = PH_IDLE;
								end
							end
							default: begin
							end
						endcase
					end
				end
			end
			ST_SQ: begin
				cmd     = CMD_SQ;
				state_d = ST_INIT_MUL;
			end
			ST_INIT_MUL: begin
				cmd     = CMD_INIT_MUL;
				state_d = ST_INIT_DEC;
			end
			ST_INIT_DEC: begin
				cmd     = CMD_INIT_DEC;
				phase_d = PH_R1;
				state_d = ST_EMIT;
			end
			ST_R1_DECIDE: begin
				if (status.lt) begin
					cmd     = CMD_R1_MUL;
					state_d = ST_R1_UPD;
				end else begin
					cmd     = CMD_R2_SQ;
					state_d = ST_R2_MUL;
				end
			end
			ST_R1_UPD: begin
				cmd     = CMD_R1_UPD;
				state_d = ST_EMIT;
			end
			ST_R2_MUL: begin
				cmd     = CMD_R2_MUL;
				state_d = ST_R2_SET;
			end
			ST_R2_SET: begin
				cmd     = CMD_R2_SET;
				phase_d = PH_R2;
				state_d = ST_EMIT;
			end
			ST_R2_EMIT: begin
				if (status.out_free) begin
					cmd     = CMD_R2_STEP;
					state_d = ST_R2_UPD;
				end
			end
			ST_R2_UPD: begin
				cmd     = CMD_R2_UPD;
				state_d = ST_READY;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd     = CMD_EMIT;
					state_d = ST_READY;
				end
			end
			ST_EMIT_LAST: begin
				if (status.out_free) begin
					cmd     = CMD_EMIT_LAST;
					state_d = ST_READY;
				end
			end
			default: begin
				state_d = ST_READY;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_READY;
			phase_q <= PH_IDLE;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

`ifndef ASSERT_OFF
	a_idle_advance_noop: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && op && phase_q == PH_IDLE) |=> (state_q == ST_READY))
		else $error("advance while idle started work");

	a_region2_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_R2_SET) |=> (phase_q == PH_R2 && state_q == ST_EMIT))
		else $error("region switch did not enter region 2");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/emr_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// emr_datapath
// Ellipse state, two shared multipliers plus a fixed a2*b2 one, decision update and output register.
// ----------------------------------------------------------------------------
module emr_datapath #(
	parameter int COORD_BITS = 11
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire emr_pkg::emr_cmd_t            cmd,
	output emr_pkg::emr_status_t              status,
	input  wire logic [COORD_BITS-1:0]        center_x,
	input  wire logic [COORD_BITS-1:0]        center_y,
	input  wire logic [COORD_BITS-1:0]        axis_end_x,
	input  wire logic [COORD_BITS-1:0]        axis_end_y,
	input  wire logic                         fill_enable,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic signed [COORD_BITS+1:0]      x_right,
	output logic signed [COORD_BITS+1:0]      x_left,
	output logic signed [COORD_BITS+1:0]      y_lower,
	output logic signed [COORD_BITS+1:0]      y_upper,
	output logic                              fill_span,
	output logic                              last
);
	import emr_pkg::*;

	localparam int C     = COORD_BITS;
	localparam int OW    = C + 2;
	localparam int MB    = 2 * C + 5;
	localparam int DEC_W = 4 * C + 4;

	localparam logic signed [MB-1:0] K1 = 1;
	localparam logic signed [MB-1:0] K2 = 2;
	localparam logic signed [MB-1:0] K3 = 3;

	logic [C-1:0]     cx_q, cy_q, ax_q, oy_q;
	logic [C:0]       ox_q;
	logic             fill_q;
	logic [2*C-1:0]   a2_q, b2_q;
	logic signed [DEC_W-1:0] dec_q, pa_q, pb_q, pc_q;

	logic [C-1:0] semi_a, semi_b;
	assign semi_a = (axis_end_x >= center_x) ? (axis_end_x - center_x) : (center_x - axis_end_x);
	assign semi_b = (axis_end_y >= center_y) ? (axis_end_y - center_y) : (center_y - axis_end_y);

	logic signed [MB-1:0] xw, yw, aw, a2w, b2w, paw, pbw;
	assign xw  = signed'({{(MB-C-1){1'b0}}, ox_q});
	assign yw  = signed'({{(MB-C){1'b0}}, oy_q});
	assign aw  = signed'({{(MB-C){1'b0}}, ax_q});
	assign a2w = signed'({{(MB-2*C){1'b0}}, a2_q});
	assign b2w = signed'({{(MB-2*C){1'b0}}, b2_q});
	assign paw = signed'(pa_q[MB-1:0]);
	assign pbw = signed'(pb_q[MB-1:0]);

	logic signed [MB-1:0]     m0a, m0b, m1a, m1b;
	logic signed [2*MB-1:0]   prod0, prod1, prod2;

	always_comb begin
		m0a = aw;
		m0b = aw;
		m1a = yw;
		m1b = yw;
		case (cmd)
			CMD_INIT_MUL: begin
				m0a = paw;
				m0b = K1 - (yw <<< 2);
			end
			CMD_R1_CMP: begin
				m0a = b2w;
				m0b = xw + K1;
				m1a = a2w;
				m1b = (yw <<< 1) - K1;
			end
			CMD_R1_MUL: begin
				m0a = b2w;
				m0b = (xw <<< 1) + K3;
				m1a = a2w;
				m1b = K2 - (yw <<< 1);
			end
			CMD_R2_SQ: begin
				m0a = (xw <<< 1) + K1;
				m0b = (xw <<< 1) + K1;
				m1a = (yw <<< 1) - K2;
				m1b = (yw <<< 1) - K2;
			end
			CMD_R2_MUL: begin
				m0a = b2w;
				m0b = paw;
				m1a = a2w;
				m1b = pbw;
			end
			CMD_R2_STEP: begin
				m0a = b2w;
				m0b = (xw <<< 1) + K2;
				m1a = a2w;
				m1b = K3 - (yw <<< 1);
			end
			default: begin
			end
		endcase
	end

	assign prod0 = m0a * m0b;
	assign prod1 = m1a * m1b;
	assign prod2 = a2w * b2w;

	logic mul_en;
	always_comb begin
		case (cmd)
			CMD_SQ, CMD_INIT_MUL, CMD_R1_CMP, CMD_R1_MUL,
			CMD_R2_SQ, CMD_R2_MUL, CMD_R2_STEP: mul_en = 1'b1;
			default: mul_en = 1'b0;
		endcase
	end

	logic signed [DEC_W-1:0] b2_dec;
	assign b2_dec = signed'({{(DEC_W-2*C){1'b0}}, b2_q});

	always_ff @(posedge clk) begin
		if (mul_en) begin
			pa_q <= prod0[DEC_W-1:0];
			pb_q <= prod1[DEC_W-1:0];
		end
		if (cmd == CMD_R2_SQ) begin
			pc_q <= prod2[DEC_W-1:0];
		end
		case (cmd)
			CMD_LOAD: begin
				cx_q   <= center_x;
				cy_q   <= center_y;
				fill_q <= fill_enable;
				ax_q   <= semi_a;
				ox_q   <= '0;
				oy_q   <= semi_b;
			end
			CMD_INIT_MUL: begin
				a2_q <= pa_q[2*C-1:0];
				b2_q <= pb_q[2*C-1:0];
			end
			CMD_INIT_DEC: begin
				dec_q <= (b2_dec <<< 2) + pa_q;
			end
			CMD_R1_UPD: begin
				if (dec_q[DEC_W-1]) begin
					dec_q <= dec_q + (pa_q <<< 2);
				end else begin
					dec_q <= dec_q + ((pa_q + pb_q) <<< 2);
					oy_q  <= oy_q - 1'b1;
				end
				ox_q <= ox_q + 1'b1;
			end
			CMD_R2_SET: begin
				dec_q <= pa_q + pb_q - (pc_q <<< 2);
			end
			CMD_R2_UPD: begin
				if (dec_q[DEC_W-1]) begin
					dec_q <= dec_q + ((pa_q + pb_q) <<< 2);
					ox_q  <= ox_q + 1'b1;
				end else begin
					dec_q <= dec_q + (pb_q <<< 2);
				end
				oy_q <= oy_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

	// output register
	logic out_load;
	assign out_load = (cmd == CMD_EMIT) || (cmd == CMD_EMIT_LAST) || (cmd == CMD_R2_STEP);

	logic [OW-1:0] cx_e, cy_e, ox_e, oy_e;
	assign cx_e = {2'b00, cx_q};
	assign cy_e = {2'b00, cy_q};
	assign ox_e = {1'b0, ox_q};
	assign oy_e = {2'b00, oy_q};

	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			x_right   <= signed'(cx_e + ox_e);
			x_left    <= signed'(cx_e - ox_e);
			y_lower   <= signed'(cy_e + oy_e);
			y_upper   <= signed'(cy_e - oy_e);
			fill_span <= fill_q;
			last      <= (cmd == CMD_EMIT_LAST);
		end
	end

	assign out_valid       = out_valid_q;
	assign status.out_free = !out_valid_q || !out_stall;
	assign status.lt       = (pa_q <<< 1) < pb_q;
	assign status.y_pos    = (oy_q != '0);

`ifndef ASSERT_OFF
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> status.out_free)
		else $error("output register overwritten while held");

	a_last_point: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_EMIT_LAST) |=> (out_valid && last))
		else $error("final point not flagged");

	a_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_EMIT || cmd == CMD_R2_STEP) |=> (out_valid && !last))
		else $error("inner point flagged as final");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/ellipse_midpoint_rasterizer_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ellipse_midpoint_rasterizer_top
// Midpoint ellipse rasterizer, one quadrant point per transaction.
//
// Input channel (in_valid / in_stall): op = 0 starts an ellipse from the
// center, the axis endpoints and the fill flag; op = 1 advances to the next
// point. Output channel (out_valid / out_stall) carries the four symmetric
// coordinates, the fill flag and last on the final point.
// One input transaction is taken at a time. From acceptance to the point
// loading the output register the sequencer issues: start LOAD, SQ,
// INIT_MUL, INIT_DEC, EMIT; region 1 step R1_CMP, R1_MUL, R1_UPD, EMIT;
// region switch R1_CMP, R2_SQ, R2_MUL, R2_SET, EMIT; region 2 step R2_STEP,
// with R2_UPD after it; final point EMIT_LAST. The input stays stalled until
// the command sequence ends. The multiply-then-accumulate chain of the
// decision term runs through two shared product registers. An advance while
// no ellipse is active gives no result. A start abandons any ellipse in progress.
// The output register lets the next transaction be accepted while a point
// waits; when out_stall holds, the sequencer waits before its next emit.
// Reset clears the sequencer and the output valid; the block then idles.
// ----------------------------------------------------------------------------
module ellipse_midpoint_rasterizer_top #(
	parameter int COORD_BITS = 11
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic                         op,
	input  wire logic [COORD_BITS-1:0]        center_x,
	input  wire logic [COORD_BITS-1:0]        center_y,
	input  wire logic [COORD_BITS-1:0]        axis_end_x,
	input  wire logic [COORD_BITS-1:0]        axis_end_y,
	input  wire logic                         fill_enable,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic signed [COORD_BITS+1:0]      x_right,
	output logic signed [COORD_BITS+1:0]      x_left,
	output logic signed [COORD_BITS+1:0]      y_lower,
	output logic signed [COORD_BITS+1:0]      y_upper,
	output logic                              fill_span,
	output logic                              last
);
	import emr_pkg::*;

	emr_cmd_t    cmd;
	emr_status_t status;

	emr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.op       (op),
		.status   (status),
		.cmd      (cmd)
	);

	emr_datapath #(
		.COORD_BITS (COORD_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.center_x    (center_x),
		.center_y    (center_y),
		.axis_end_x  (axis_end_x),
		.axis_end_y  (axis_end_y),
		.fill_enable (fill_enable),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.x_right     (x_right),
		.x_left      (x_left),
		.y_lower     (y_lower),
		.y_upper     (y_upper),
		.fill_span   (fill_span),
		.last        (last)
	);

endmodule
`default_nettype wire
